// ===== rtl/accumulator_cpu_machine_cycle_assert.svh =====
// Assertion macros shared by the accumulator CPU RTL.
`ifndef ACCUMULATOR_CPU_MACHINE_CYCLE_ASSERT_SVH
`define ACCUMULATOR_CPU_MACHINE_CYCLE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ACM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define ACM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/acm_pkg.sv =====
`timescale 1ns / 1ps

package acm_pkg;

    localparam int MEM_WORDS = 4096;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int DATA_W    = 16;
    localparam int PC_W      = 12;
    localparam int DEV_W     = 6;
    localparam int BYTE_W    = 8;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 72;

    localparam logic [DATA_W-1:0] SWITCH_RESET = 16'b1000000000000111;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_RUN   = 2'd1,
        ACT_START = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef enum logic [3:0] {
        OP_HLT = 4'h0,
        OP_ADD = 4'h1,
        OP_XOR = 4'h2,
        OP_AND = 4'h3,
        OP_IOR = 4'h4,
        OP_NOT = 4'h5,
        OP_LDA = 4'h6,
        OP_STA = 4'h7,
        OP_SRJ = 4'h8,
        OP_JMA = 4'h9,
        OP_JMP = 4'hA,
        OP_INP = 4'hB,
        OP_OUT = 4'hC,
        OP_RAL = 4'hD,
        OP_CSA = 4'hE,
        OP_NOP = 4'hF
    } t_opcode;

    typedef enum logic [2:0] {
        HALT_NONE  = 3'd0,
        HALT_HLT   = 3'd1,
        HALT_OVER  = 3'd2,
        HALT_UNDER = 3'd3,
        HALT_STOP  = 3'd4
    } t_halt;

    typedef enum logic {
        PH_FETCH = 1'b0,
        PH_EXEC  = 1'b1
    } t_phase;

    // Packed MSB first, so the accumulator lands in the lowest bits of tdata.
    typedef struct packed {
        logic [BYTE_W-1:0] out_data;
        logic [DEV_W-1:0]  device_select;
        logic              io_is_output;
        logic              io_valid;
        t_halt             halt_cause;
        logic              running;
        logic              in_execute;
        logic [DATA_W-1:0] instruction;
        logic [PC_W-1:0]   program_counter;
        logic [DATA_W-1:0] accumulator;
    } t_result;

endpackage

// ===== rtl/acm_ram.sv =====
`timescale 1ns / 1ps

module acm_ram #(
    parameter int DATA_W = 16,
    parameter int DEPTH  = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/accumulator_cpu_machine_cycle.sv =====
`timescale 1ns / 1ps
// Each accepted transaction accesses the single-port word memory at acceptance; the registers
//   update from its read data at commit, which also loads the output register feeding m_axis.
//   Commit waits while a held result is not taken; no new transaction is accepted until then.
// The output register decouples the sides: a new transaction is taken while a result waits.
// Reset (i_rst_n low, synchronous): ACC, PC, IR, operand latch cleared, fetch phase,
//   running, no halt cause, switch register 0x8007; memory contents are not cleared.

module accumulator_cpu_machine_cycle
    import acm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // mem_address [11:0], mem_data [27:12], in_data [35:28], zero pad
    input  logic [S_TDATA_W-1:0] s_axis_tdata,
    // action [1:0]
    input  logic [S_TUSER_W-1:0] s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // accumulator [15:0], program_counter [27:16], instruction [43:28],
    // in_execute [44], running [45], halt_cause [48:46], io_valid [49],
    // io_is_output [50], device_select [56:51], out_data [64:57], zero pad
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [DATA_W-1:0]    i_cfg_data
);

    `include "accumulator_cpu_machine_cycle_assert.svh"

    // Architectural state
    logic [DATA_W-1:0] r_acc, n_acc;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic [DATA_W-1:0] r_instr, n_instr;
    logic [DATA_W-1:0] r_opl, n_opl;
    t_phase            r_phase, n_phase;
    logic              r_power, n_power;
    t_halt             r_halt, n_halt;
    logic [BYTE_W-1:0] r_outl, n_outl;
    logic [DEV_W-1:0]  r_dev, n_dev;
    logic [DATA_W-1:0] r_switch;

    // Memory-access stage: one transaction in flight between acceptance and commit
    logic              r_busy;
    t_action           r_action;
    logic [BYTE_W-1:0] r_in_data;

    // Output register
    logic              r_out_valid;
    t_result           r_out;

    logic              w_accept;
    logic              w_commit;
    t_action           w_act_in;
    logic [PC_W-1:0]   w_in_addr;
    logic [DATA_W-1:0] w_in_mem_data;
    logic [BYTE_W-1:0] w_in_data;

    logic              w_mem_we;
    logic              w_mem_re;
    logic [MEM_AW-1:0] w_mem_addr;
    logic [DATA_W-1:0] w_mem_wdata;
    logic [DATA_W-1:0] w_rdata;

    t_opcode           w_op_fetch;
    t_opcode           w_op_exec;
    logic [PC_W-1:0]   w_pc_inc;
    logic [DATA_W-1:0] w_sum;
    logic              w_io_valid;
    logic              w_io_out;
    t_result           w_result;

    assign w_act_in      = t_action'(s_axis_tuser);
    assign w_in_addr     = s_axis_tdata[11:0];
    assign w_in_mem_data = s_axis_tdata[27:12];
    assign w_in_data     = s_axis_tdata[35:28];

    // Interlock: next transaction depends on registers updated at commit
    assign s_axis_tready = !r_busy;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_commit      = r_busy && (!r_out_valid || m_axis_tready);

    assign o_cfg_ready   = 1'b1;

    assign w_op_fetch = t_opcode'(w_rdata[15:12]);
    assign w_op_exec  = t_opcode'(r_instr[15:12]);
    assign w_pc_inc   = r_pc + 12'd1;
    assign w_sum      = r_opl + w_rdata;

    // Memory port, driven at acceptance. STA writes here; the commit has nothing to store.
    always_comb begin
        w_mem_we    = 1'b0;
        w_mem_re    = 1'b0;
        w_mem_addr  = r_pc[MEM_AW-1:0];
        w_mem_wdata = r_acc;
        if (w_act_in == ACT_WRITE) begin
            w_mem_we    = w_accept;
            w_mem_addr  = w_in_addr[MEM_AW-1:0];
            w_mem_wdata = w_in_mem_data;
        end else if (w_act_in == ACT_RUN && r_power) begin
            if (r_phase == PH_EXEC) begin
                w_mem_addr = r_instr[MEM_AW-1:0];
                if (w_op_exec == OP_STA) begin
                    w_mem_we = w_accept;
                end else begin
                    w_mem_re = w_accept;
                end
            end else begin
                w_mem_re = w_accept;
            end
        end
    end

    acm_ram #(
        .DATA_W (DATA_W),
        .DEPTH  (MEM_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (w_mem_wdata),
        .o_rdata (w_rdata)
    );

    // Commit: register update from the read data of the transaction in flight
    always_comb begin
        n_acc      = r_acc;
        n_pc       = r_pc;
        n_instr    = r_instr;
        n_opl      = r_opl;
        n_phase    = r_phase;
        n_power    = r_power;
        n_halt     = r_halt;
        n_outl     = r_outl;
        n_dev      = r_dev;
        w_io_valid = 1'b0;
        w_io_out   = 1'b0;
        case (r_action)
            ACT_RUN: begin
                if (r_power && r_phase == PH_FETCH) begin
                    n_pc    = w_pc_inc;
                    n_instr = w_rdata;
                    case (w_op_fetch)
                        OP_HLT: begin
                            n_power = 1'b0;
                            n_halt  = HALT_HLT;
                        end
                        OP_ADD, OP_XOR, OP_AND, OP_IOR, OP_NOT, OP_RAL: begin
                            n_opl   = r_acc;
                            n_phase = PH_EXEC;
                        end
                        OP_LDA, OP_STA: begin
                            n_phase = PH_EXEC;
                        end
                        OP_SRJ: begin
                            // incremented PC is ORed into ACC before the jump
                            n_acc = r_acc | {4'b0000, w_pc_inc};
                            n_pc  = w_rdata[11:0];
                        end
                        OP_JMA: begin
                            if (r_acc[15]) begin
                                n_pc = w_rdata[11:0];
                            end
                        end
                        OP_JMP: begin
                            n_pc = w_rdata[11:0];
                        end
                        OP_INP: begin
                            n_acc   = '0;
                            n_dev   = w_rdata[5:0];
                            n_phase = PH_EXEC;
                        end
                        OP_OUT: begin
                            n_outl  = r_acc[15:8];
                            n_dev   = w_rdata[5:0];
                            n_phase = PH_EXEC;
                        end
                        OP_CSA: begin
                            n_acc = r_switch;
                        end
                        default: begin
                        end
                    endcase
                end else if (r_power) begin
                    n_phase = PH_FETCH;
                    case (w_op_exec)
                        OP_ADD: begin
                            // sum is kept even when the signed add wraps
                            n_acc = w_sum;
                            if (r_opl[15] && w_rdata[15] && !w_sum[15]) begin
                                n_power = 1'b0;
                                n_halt  = HALT_UNDER;
                            end else if (!r_opl[15] && !w_rdata[15] && w_sum[15]) begin
                                n_power = 1'b0;
                                n_halt  = HALT_OVER;
                            end
                        end
                        OP_XOR: n_acc = r_opl ^ w_rdata;
                        OP_AND: n_acc = r_opl & w_rdata;
                        OP_IOR: n_acc = r_opl | w_rdata;
                        OP_NOT: n_acc = ~r_opl;
                        OP_LDA: n_acc = w_rdata;
                        OP_INP: begin
                            n_acc      = {8'h00, r_in_data};
                            w_io_valid = 1'b1;
                        end
                        OP_OUT: begin
                            w_io_valid = 1'b1;
                            w_io_out   = 1'b1;
                        end
                        OP_RAL: n_acc = {r_opl[14:0], r_opl[15]};
                        default: begin
                        end
                    endcase
                end
            end
            ACT_START: begin
                n_power = 1'b1;
                n_halt  = HALT_NONE;
            end
            ACT_STOP: begin
                // a second stop keeps the earlier cause
                if (r_power) begin
                    n_power = 1'b0;
                    n_halt  = HALT_STOP;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_result.accumulator     = n_acc;
        w_result.program_counter = n_pc;
        w_result.instruction     = n_instr;
        w_result.in_execute      = (n_phase == PH_EXEC);
        w_result.running         = n_power;
        w_result.halt_cause      = n_halt;
        w_result.io_valid        = w_io_valid;
        w_result.io_is_output    = w_io_out;
        w_result.device_select   = n_dev;
        w_result.out_data        = n_outl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= '0;
            r_pc     <= '0;
            r_instr  <= '0;
            r_opl    <= '0;
            r_phase  <= PH_FETCH;
            r_power  <= 1'b1;
            r_halt   <= HALT_NONE;
            r_outl   <= '0;
            r_dev    <= '0;
        end else if (w_commit) begin
            r_acc    <= n_acc;
            r_pc     <= n_pc;
            r_instr  <= n_instr;
            r_opl    <= n_opl;
            r_phase  <= n_phase;
            r_power  <= n_power;
            r_halt   <= n_halt;
            r_outl   <= n_outl;
            r_dev    <= n_dev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_switch <= SWITCH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_switch <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_commit) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action  <= w_act_in;
            r_in_data <= w_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_commit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W - $bits(t_result)){1'b0}}, r_out};

    `ACM_ASSERT_NEXT(a_accept_blocks_next, w_accept, !s_axis_tready,
        "transaction accepted while the previous one is still in flight")
    `ACM_ASSERT_NEXT(a_commit_fills_out, w_commit, r_out_valid,
        "committed result did not reach the output register")
    `ACM_ASSERT_NOW(a_run_halt_match, r_out_valid,
        r_out.running == (r_out.halt_cause == HALT_NONE),
        "running flag and halt cause disagree")
    `ACM_ASSERT_NOW(a_io_ends_execute, r_out_valid && r_out.io_valid,
        !r_out.in_execute && r_out.running,
        "I/O completion reported outside an execute cycle")

endmodule
